[design/dcbp_pkg.sv]
package dcbp_pkg;

  // Frame and command bytes.
  localparam logic [7:0] BYTE_START  = 8'h01;
  localparam logic [7:0] BYTE_NULL   = 8'h00;
  localparam logic [7:0] CMD_HOTEND  = 8'h20;
  localparam logic [7:0] CMD_BED     = 8'h21;
  localparam logic [7:0] CMD_FAN     = 8'h22;
  localparam logic [7:0] CMD_SPINDLE = 8'h23;
  localparam logic [7:0] CMD_PAGE    = 8'h10;
  localparam logic [7:0] CMD_GCODE   = 8'h30;

  // Result kinds.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_HOTEND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FAN     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SPINDLE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PAGE    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_GCODE   = 3'd5;

  localparam int VALUE_W = 24;
  localparam int CHAR_W  = 8;

  // Number of little-endian value bytes per target command (1 to 3).
  localparam int VALUE_BYTES = 3;

  // A gcode run never keeps more than this many characters.
  localparam int RUN_LIMIT = 31;
  localparam int CNT_W     = 5;

  localparam int GCODE_BUFFER_BYTES_DEF = 32;
  localparam int QUEUE_DEPTH_DEF        = 2;

  // Percent to pwm: floor(pct * 255 / 100), saturated at 255.
  localparam logic [7:0]  PCT_FULL  = 8'd100;
  localparam logic [12:0] RECIP_100 = 13'd5243;  // 2^19 / 100, rounded up
  localparam int          RECIP_SH  = 19;

  // One job handed from the parser to the result sequencer.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [CNT_W-1:0]   count;
    logic               overflow;
  } job_t;

endpackage

[design/dcbp_if.sv]
interface dcbp_in_if;
  import dcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dcbp_out_if;
  import dcbp_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic               last;
  logic               truncated;

  modport source (output valid, output kind, output value, output last, output truncated,
                  input ready);
  modport sink (input valid, input kind, input value, input last, input truncated,
                output ready);
endinterface

[design/dcbp_ram.sv]
module dcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/dcbp_front.sv]
module dcbp_front #(
  parameter int GCODE_BUFFER_BYTES = dcbp_pkg::GCODE_BUFFER_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  dcbp_in_if.sink                           byte_in,
  output logic                              push,
  output dcbp_pkg::job_t                    push_job,
  input  logic                              q_full,
  input  logic                              run_done,
  output logic                              wr_en,
  output logic [$clog2(GCODE_BUFFER_BYTES)-1:0] wr_addr,
  output logic [dcbp_pkg::CHAR_W-1:0]       wr_data
);
  import dcbp_pkg::*;

  localparam int ADDR_W = $clog2(GCODE_BUFFER_BYTES);
  localparam int CAP    = (GCODE_BUFFER_BYTES - 1 < RUN_LIMIT) ?
                          GCODE_BUFFER_BYTES - 1 : RUN_LIMIT;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_ARGS = 2'd2;

  logic [1:0]         phase;
  logic [7:0]         cmd;
  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] acc;
  logic               ovf;
  logic               gcode_busy;

  logic               accept;
  logic [7:0]         c;
  logic               is_target;
  logic               cmd_known;
  logic               in_gcode;
  logic [VALUE_W-1:0] pwm;
  logic [14:0]        pct_x255;
  logic [27:0]        prod;

  assign c         = byte_in.rx_byte;
  assign in_gcode  = (phase == PH_ARGS) && (cmd == CMD_GCODE);
  assign byte_in.ready = !q_full && !(in_gcode && gcode_busy);
  assign accept    = byte_in.valid && byte_in.ready;
  assign is_target = (cmd == CMD_HOTEND) || (cmd == CMD_BED) ||
                     (cmd == CMD_FAN) || (cmd == CMD_SPINDLE);
  assign cmd_known = (c == CMD_HOTEND) || (c == CMD_BED) || (c == CMD_FAN) ||
                     (c == CMD_SPINDLE) || (c == CMD_PAGE) || (c == CMD_GCODE);

  // Anything above 100 percent saturates, so only seven bits reach the multiplier.
  assign pct_x255 = {acc[6:0], 8'b0} - {8'b0, acc[6:0]};
  assign prod     = {13'b0, pct_x255} * {15'b0, RECIP_100};
  assign pwm      = (acc > VALUE_W'(PCT_FULL)) ? VALUE_W'(8'hFF) :
                    VALUE_W'(prod[RECIP_SH +: 8]);

  always_comb begin
    push     = 1'b0;
    push_job = '0;
    wr_en    = 1'b0;
    wr_addr  = ADDR_W'(cnt);
    wr_data  = c;
    if (accept && phase == PH_ARGS) begin
      if (is_target) begin
        if (!(cnt < CNT_W'(VALUE_BYTES))) begin
          push          = 1'b1;
          push_job.kind = {1'b0, cmd[1:0]};
          push_job.value = cmd[1] ? pwm : acc;
        end
      end else if (cmd == CMD_PAGE) begin
        push           = 1'b1;
        push_job.kind  = KIND_PAGE;
        push_job.value = VALUE_W'(c);
      end else if (cmd == CMD_GCODE) begin
        if (c != BYTE_NULL) begin
          wr_en = cnt < CNT_W'(CAP);
        end else begin
          push              = 1'b1;
          push_job.kind     = KIND_GCODE;
          push_job.count    = cnt;
          push_job.overflow = ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      cmd        <= '0;
      cnt        <= '0;
      acc        <= '0;
      ovf        <= 1'b0;
      gcode_busy <= 1'b0;
    end else begin
      if (run_done) begin
        gcode_busy <= 1'b0;
      end
      if (push && push_job.kind == KIND_GCODE) begin
        gcode_busy <= 1'b1;
      end
      if (accept) begin
        unique case (phase)
          PH_CMD: begin
            cmd   <= c;
            cnt   <= '0;
            acc   <= '0;
            ovf   <= 1'b0;
            phase <= cmd_known ? PH_ARGS : PH_IDLE;
          end
          PH_ARGS: begin
            if (is_target) begin
              if (cnt < CNT_W'(VALUE_BYTES)) begin
                acc <= acc | (VALUE_W'(c) << {cnt[1:0], 3'b000});
                cnt <= cnt + 1'b1;
              end else begin
                phase <= PH_IDLE;
              end
            end else if (cmd == CMD_GCODE) begin
              if (c != BYTE_NULL) begin
                if (cnt < CNT_W'(CAP)) begin
                  cnt <= cnt + 1'b1;
                end else begin
                  ovf <= 1'b1;
                end
              end else begin
                phase <= PH_IDLE;
              end
            end else begin
              phase <= PH_IDLE;
            end
          end
          default: begin
            phase <= (c == BYTE_START) ? PH_CMD : PH_IDLE;
          end
        endcase
      end
    end
  end

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    in_gcode |-> cnt <= CNT_W'(CAP))
    else $error("gcode character count beyond buffer capacity");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !gcode_busy)
    else $error("gcode buffer written while a run is still being read");

endmodule

[design/dcbp_queue.sv]
module dcbp_queue #(
  parameter int DEPTH = dcbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dcbp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output dcbp_pkg::job_t head,
  output logic           empty
);
  import dcbp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] occ;

  assign full  = occ == OCC_W'(DEPTH);
  assign empty = occ == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        occ <= occ + 1'b1;
      end else if (pop && !push) begin
        occ <= occ - 1'b1;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job queue written while full");

endmodule

[design/dcbp_back.sv]
module dcbp_back #(
  parameter int GCODE_BUFFER_BYTES = dcbp_pkg::GCODE_BUFFER_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  dcbp_pkg::job_t                        q_head,
  output logic                                  q_pop,
  output logic                                  rd_en,
  output logic [$clog2(GCODE_BUFFER_BYTES)-1:0] rd_addr,
  input  logic [dcbp_pkg::CHAR_W-1:0]           rd_data,
  output logic                                  run_done,
  dcbp_out_if.source                            result
);
  import dcbp_pkg::*;

  localparam int ADDR_W = $clog2(GCODE_BUFFER_BYTES);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_WAIT = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic             ovf;

  logic             out_free;
  logic             more;

  assign out_free = !result.valid || result.ready;
  assign more     = idx < cnt;
  assign q_pop    = (state == B_IDLE) && !q_empty &&
                    ((q_head.kind == KIND_GCODE) || out_free);
  assign rd_en    = (state == B_RUN) && more;
  assign rd_addr  = ADDR_W'(idx);
  assign run_done = (state == B_RUN) && !more && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result.valid <= 1'b0;
      idx          <= '0;
      cnt          <= '0;
      ovf          <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        B_RUN: begin
          if (more) begin
            state <= B_WAIT;
          end else if (out_free) begin
            result.valid <= 1'b1;
            state        <= B_IDLE;
          end
        end
        B_WAIT: begin
          if (out_free) begin
            result.valid <= 1'b1;
            idx          <= idx + 1'b1;
            state        <= B_RUN;
          end
        end
        default: begin
          if (q_pop) begin
            if (q_head.kind == KIND_GCODE) begin
              idx   <= '0;
              cnt   <= q_head.count;
              ovf   <= q_head.overflow;
              state <= B_RUN;
            end else begin
              result.valid <= 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Payload register, loaded alongside valid.
  always_ff @(posedge clk) begin
    unique case (state)
      B_RUN: begin
        if (!more && out_free) begin
          result.kind      <= KIND_GCODE;
          result.value     <= '0;
          result.last      <= 1'b1;
          result.truncated <= ovf;
        end
      end
      B_WAIT: begin
        if (out_free) begin
          result.kind      <= KIND_GCODE;
          result.value     <= VALUE_W'(rd_data);
          result.last      <= 1'b0;
          result.truncated <= ovf;
        end
      end
      default: begin
        if (q_pop && q_head.kind != KIND_GCODE) begin
          result.kind      <= q_head.kind;
          result.value     <= q_head.value;
          result.last      <= 1'b1;
          result.truncated <= 1'b0;
        end
      end
    endcase
  end

  a_wait_in_range: assert property (@(posedge clk) disable iff (rst)
    state == B_WAIT |-> idx < cnt)
    else $error("character read past the end of the run");

  a_done_emits_last: assert property (@(posedge clk) disable iff (rst)
    run_done |=> result.valid && result.last && result.kind == KIND_GCODE)
    else $error("gcode run finished without its closing item");

endmodule

[design/display_command_byte_parser.sv]
// A single result (target, pwm or page) goes from the byte that triggers it through the
// job queue into the output register; the first character of a gcode run also passes
// through the sequencer's run state and a buffer read, the closing item of an empty run
// only the run state. Throughput: one input byte per cycle, held off while the job queue
// is full or gcode bytes wait for the previous run to be read out; each gcode character
// is read and registered before the next read starts. Reset is synchronous, active high.
module display_command_byte_parser #(
  parameter int GCODE_BUFFER_BYTES = dcbp_pkg::GCODE_BUFFER_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dcbp_in_if.sink    byte_in,
  dcbp_out_if.source result
);
  import dcbp_pkg::*;

  localparam int ADDR_W = $clog2(GCODE_BUFFER_BYTES);

  // Jobs from the parser to the sequencer.
  logic  push;
  job_t  push_job;
  logic  q_full;
  logic  q_pop;
  job_t  q_head;
  logic  q_empty;

  // Gcode character buffer: written by the parser, read by the sequencer.
  // Reset leaves its contents alone; only characters of the current run are read.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0] rd_data;

  // The sequencer tells the parser when the buffer is free for the next run.
  logic run_done;

  // The parser tracks the frame phase, gathers value bytes, scales fan and spindle
  // percentages, and writes gcode characters into the buffer. Each complete command
  // becomes one job. While a gcode run is still being read out, the parser holds
  // off transfers of further gcode bytes so that the buffer is never overwritten.
  dcbp_front #(
    .GCODE_BUFFER_BYTES(GCODE_BUFFER_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .push    (push),
    .push_job(push_job),
    .q_full  (q_full),
    .run_done(run_done),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // A short job queue lets the parser keep taking bytes while results wait.
  dcbp_queue #(
    .DEPTH(QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty)
  );

  dcbp_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(GCODE_BUFFER_BYTES)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // The sequencer turns each job into result transfers: one for a single command,
  // or every buffered character followed by a zero item for a gcode run.
  dcbp_back #(
    .GCODE_BUFFER_BYTES(GCODE_BUFFER_BYTES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .run_done(run_done),
    .result  (result)
  );

endmodule

[verif/dcbp_checker.sv]
module dcbp_checker #(
  parameter int GCODE_BUFFER_BYTES = dcbp_pkg::GCODE_BUFFER_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  dcbp_in_if   byte_in,
  dcbp_out_if  result,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dcbp_pkg::*;

  typedef enum logic [1:0] {
    WAIT_START,
    WAIT_CMD,
    GATHER
  } frame_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               truncated;
  } action_t;

  // Characters a gcode run can keep before further ones are dropped.
  localparam int KEEP_MAX = (GCODE_BUFFER_BYTES - 1 < RUN_LIMIT) ?
                            GCODE_BUFFER_BYTES - 1 : RUN_LIMIT;

  frame_phase_t       phase;
  logic [7:0]         cmd;
  int                 nbytes;
  logic [VALUE_W-1:0] acc;
  logic [CHAR_W-1:0]  run_chars [RUN_LIMIT];
  logic               dropped;
  action_t            expected_actions[$];
  int                 mismatch_count;

  function automatic logic [VALUE_W-1:0] pct_to_pwm(input logic [VALUE_W-1:0] pct);
    logic [63:0] scaled;
    scaled = 64'(pct) * 64'd255 / 64'd100;
    return (scaled > 64'd255) ? VALUE_W'(255) : VALUE_W'(scaled);
  endfunction

  task automatic expect_action(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                               input logic last, input logic truncated);
    action_t a;
    a.kind      = kind;
    a.value     = value;
    a.last      = last;
    a.truncated = truncated;
    expected_actions.push_back(a);
  endtask

  // Advances the frame parser by one received byte and queues what it causes.
  task automatic parse_byte(input logic [7:0] b);
    logic [KIND_W-1:0] kind;
    case (phase)
      WAIT_CMD: begin
        cmd     = b;
        nbytes  = 0;
        acc     = '0;
        dropped = 1'b0;
        case (b)
          CMD_HOTEND, CMD_BED, CMD_FAN, CMD_SPINDLE, CMD_PAGE, CMD_GCODE: phase = GATHER;
          default: phase = WAIT_START;
        endcase
      end
      GATHER: begin
        case (cmd)
          CMD_HOTEND, CMD_BED, CMD_FAN, CMD_SPINDLE: begin
            if (nbytes < VALUE_BYTES) begin
              acc = acc | (VALUE_W'(b) << (8 * nbytes));
              nbytes++;
            end else begin
              case (cmd)
                CMD_HOTEND: kind = KIND_HOTEND;
                CMD_BED:    kind = KIND_BED;
                CMD_FAN:    kind = KIND_FAN;
                default:    kind = KIND_SPINDLE;
              endcase
              if (kind == KIND_FAN || kind == KIND_SPINDLE) begin
                expect_action(kind, pct_to_pwm(acc), 1'b1, 1'b0);
              end else begin
                expect_action(kind, acc, 1'b1, 1'b0);
              end
              phase = WAIT_START;
            end
          end
          CMD_PAGE: begin
            expect_action(KIND_PAGE, VALUE_W'(b), 1'b1, 1'b0);
            phase = WAIT_START;
          end
          CMD_GCODE: begin
            if (b != BYTE_NULL) begin
              if (nbytes < KEEP_MAX) begin
                run_chars[nbytes] = b;
                nbytes++;
              end else begin
                dropped = 1'b1;
              end
            end else begin
              for (int i = 0; i < nbytes; i++) begin
                expect_action(KIND_GCODE, VALUE_W'(run_chars[i]), 1'b0, dropped);
              end
              expect_action(KIND_GCODE, '0, 1'b1, dropped);
              phase = WAIT_START;
            end
          end
          default: phase = WAIT_START;
        endcase
      end
      default: phase = (b == BYTE_START) ? WAIT_CMD : WAIT_START;
    endcase
  endtask

  task automatic check_action();
    action_t got;
    action_t want;
    got.kind      = result.kind;
    got.value     = result.value;
    got.last      = result.last;
    got.truncated = result.truncated;
    if (expected_actions.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("dcbp_checker: unexpected result kind %0d value 0x%06h last %0d trunc %0d",
                 got.kind, got.value, got.last, got.truncated);
      end
    end else begin
      want = expected_actions.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("dcbp_checker: expected kind %0d value 0x%06h last %0d trunc %0d",
                   want.kind, want.value, want.last, want.truncated);
          $display("dcbp_checker:      got kind %0d value 0x%06h last %0d trunc %0d",
                   got.kind, got.value, got.last, got.truncated);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase   = WAIT_START;
      cmd     = '0;
      nbytes  = 0;
      acc     = '0;
      dropped = 1'b0;
      expected_actions.delete();
    end else begin
      if (byte_in.valid && byte_in.ready) begin
        parse_byte(byte_in.rx_byte);
      end
      if (result.valid && result.ready) begin
        check_action();
      end
    end
    fails   <= mismatch_count;
    pending <= expected_actions.size();
  end

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dcbp_pkg::*;

  // Cycles without any transfer on either channel before the run is abandoned.
  // The longest legitimate quiet stretch is the long receiver hold-off below.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_BYTES = 120;

  logic clk;
  logic rst;

  dcbp_in_if  byte_in ();
  dcbp_out_if result ();

  int fail_count;
  int pending_count;
  int quiet_cycles = 0;
  int sent_count = 0;

  // Random idling on both sides is switched off for the last part of the run.
  bit idle_on = 1'b1;
  // Asks the receiver to hold off for a long stretch so the block backs up.
  bit hold_req = 1'b0;

  display_command_byte_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .result  (result)
  );

  dcbp_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .result  (result),
    .fails   (fail_count),
    .pending (pending_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offers one byte, sometimes after a random idle burst, and returns once the
  // transfer has taken place. Bytes the parser merely ignores are not counted.
  task automatic send(input logic [7:0] b, input bit counts = 1'b1);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      byte_in.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    byte_in.valid   <= 1'b1;
    byte_in.rx_byte <= b;
    do @(posedge clk); while (!byte_in.ready);
    if (counts) begin
      sent_count++;
    end
  endtask

  // A target or pwm frame: start, command, little-endian value bytes, and a
  // trigger byte whose own value does not matter.
  task automatic send_target(input logic [7:0] cmd, input logic [VALUE_W-1:0] v);
    send(BYTE_START);
    send(cmd);
    for (int i = 0; i < VALUE_BYTES; i++) begin
      send(v[8*i +: 8]);
    end
    send(8'($urandom_range(0, 255)));
  endtask

  task automatic send_page(input logic [7:0] p);
    send(BYTE_START);
    send(CMD_PAGE);
    send(p);
  endtask

  // A gcode frame with random nonzero characters, closed by the zero byte.
  task automatic send_gcode(input int len);
    send(BYTE_START);
    send(CMD_GCODE);
    for (int i = 0; i < len; i++) begin
      send(8'($urandom_range(1, 255)));
    end
    send(BYTE_NULL);
  endtask

  function automatic logic [7:0] pick_target_cmd();
    case ($urandom_range(0, 3))
      0:       return CMD_HOTEND;
      1:       return CMD_BED;
      2:       return CMD_FAN;
      default: return CMD_SPINDLE;
    endcase
  endfunction

  // Receiver: ready in random bursts, plus one long hold-off on request. Each
  // pass of the loop makes exactly one assignment to ready in its time step.
  initial begin
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        result.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: any transfer on either side counts as progress.
  always @(posedge clk) begin
    if (rst || (byte_in.valid && byte_in.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    bit hold_done;
    logic [VALUE_W-1:0] v;
    logic [7:0] tcmd;
    int len;

    hold_done = 1'b0;
    rst             <= 1'b1;
    byte_in.valid   <= 1'b0;
    byte_in.rx_byte <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Stray bytes before any start byte are ignored, including
    // ones that look like command codes.
    send(8'hFF, 1'b0);
    send(CMD_PAGE, 1'b0);

    // Value extremes, including zero bytes inside the value.
    send_target(CMD_HOTEND, 24'h000000);
    send_target(CMD_HOTEND, 24'hFFFFFF);
    send_target(CMD_BED, 24'h123456);

    // Percent scaling: full, zero, just above full (saturates), a huge value,
    // and two cases where the division truncates.
    send_target(CMD_FAN, 24'd100);
    send_target(CMD_FAN, 24'd0);
    send_target(CMD_FAN, 24'd101);
    send_target(CMD_FAN, 24'hFFFFFF);
    send_target(CMD_SPINDLE, 24'd50);
    send_target(CMD_SPINDLE, 24'd39);

    send_page(8'h00);
    send_page(8'hFF);

    // An empty gcode run yields only its closing null item; a run that fills
    // the run capacity exactly is not truncated; a longer one drops the excess and
    // flags it on every item.
    send_gcode(0);
    send_gcode(3);
    send_gcode(31);
    send_gcode(40);

    // An unknown command drops the frame at once, so the page code after it is
    // just an ignored byte. A start byte in the command slot is unknown too.
    send(BYTE_START);
    send(8'h55);
    send(CMD_PAGE, 1'b0);
    send(BYTE_START);
    send(BYTE_START);
    send(CMD_PAGE, 1'b0);
    send(BYTE_START);
    send(BYTE_NULL);
    send_page(8'h5A);

    // Random part: mostly well-formed frames with random content, the rest
    // noise, unknown commands and frames cut short.
    sent_count = 0;
    while (sent_count < RANDOM_BYTES) begin
      if (!hold_done && sent_count >= 30) begin
        // Hold the receiver off while a few gcode runs pour in, so the result
        // side backs up and the block has to stall its input.
        hold_done = 1'b1;
        hold_req  = 1'b1;
        send_gcode(10);
        send_gcode(12);
        send_gcode(8);
      end
      if (sent_count >= RANDOM_BYTES - 30) begin
        idle_on = 1'b0;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          tcmd = pick_target_cmd();
          if ($urandom_range(0, 1) == 0) begin
            v = VALUE_W'($urandom_range(0, 120));
          end else begin
            v = VALUE_W'($urandom());
          end
          send_target(tcmd, v);
        end
        10, 11: send_page(8'($urandom_range(0, 255)));
        12, 13, 14, 15: begin
          if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(28, 40);
          end else begin
            len = $urandom_range(0, 8);
          end
          send_gcode(len);
        end
        16: send(8'($urandom_range(0, 255)), 1'b0);
        17: begin
          send(BYTE_START);
          send(8'($urandom_range(0, 255)));
        end
        18: begin
          send(BYTE_START);
          send(BYTE_START);
          send(8'($urandom_range(0, 255)));
        end
        default: begin
          // A value frame cut short: the following bytes carry on the frame.
          send(BYTE_START);
          send(pick_target_cmd());
          send(8'($urandom_range(0, 255)));
        end
      endcase
    end

    // Send a last page frame; it also feeds bytes to a frame that is still open.
    send(BYTE_START);
    send(CMD_PAGE);
    send(8'h01);
    byte_in.valid <= 1'b0;

    // Let the checker see the last transfer before looking at what is pending.
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
design/dcbp_pkg.sv
design/dcbp_if.sv
design/dcbp_ram.sv
design/dcbp_front.sv
design/dcbp_queue.sv
design/dcbp_back.sv
design/display_command_byte_parser.sv
verif/dcbp_checker.sv
verif/tb.sv
